@@ design/rgd_pkg.sv @@
// Shared types and constants for the lidar point range gate and decimator.
// No dependencies; imported by every module of the block but rgd_root_unit.
`default_nettype none

package rgd_pkg;

   // Fixed field widths
   localparam int STAMP_W      = 63;
   localparam int RING_W       = 8;
   localparam int ROOT_OUT_W   = 20;
   localparam int REL_W        = 32;
   localparam int RANGE_SQ_W   = 48;
   localparam int CSR_DATA_W   = 48;
   localparam int CSR_IDX_W    = 2;

   // Fraction digits of the two chained roots
   localparam int ROOT1_FRAC   = 8;
   localparam int ROOT2_FRAC   = 4;

   localparam logic [ROOT_OUT_W-1:0] ROOT_OUT_MAX = '1;
   localparam logic [REL_W-1:0]      REL_POS_MAX  = 32'h7FFF_FFFF;
   localparam logic [REL_W-1:0]      REL_NEG_MIN  = 32'h8000_0000;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_EVERY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RANGE_SQ = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE_SQ = 2'd2;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } rgd_axis_type;

   // Control of the square-accumulate unit
   typedef struct packed {
      logic         clr;
      logic         mul;
      logic         acc;
      rgd_axis_type sel;
   } rgd_sq_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_GATE,
      ST_ROOT1,
      ST_ROOT2,
      ST_EMIT
   } rgd_state_type;

endpackage

`default_nettype wire

@@ design/lidar_point_range_gate_decimator.sv @@
// Top level of the lidar point range gate and decimator: handshake, frame
// and decimation state, sequencer. Uses rgd_pkg, rgd_sq_acc, rgd_root_unit.
`default_nettype none

// Points arrive as transfers on req_; a point with req_tuser set starts a
// frame, latching its timestamp and restarting the keep-one-in-N phase. A
// point that is not a decimation candidate is absorbed in its transfer cycle
// and req_tready stays high. A candidate occupies the block: square-accumulate
// builds x^2+y^2+z^2 through one shared multiplier, then ST_GATE checks it
// against min/max_range_sq (a point outside the window ends here), then one
// shared digit-recurrence root unit runs twice, one root bit per cycle:
// ROOT_W = ceil(range bits/2)+8 steps give the distance in Q.8, then
// ceil(ROOT_W/2)+4 steps give its square root in Q.8. A kept point holds
// the block from its transfer until ST_EMIT hands the result on and
// req_tready rises again; the two roots take most of that time. The result
// waits in an output register, so the next point is taken while rsp_tvalid
// is still held. Configuration writes are taken at any edge with csr_wen
// high and must only occur while the block is idle.

module lidar_point_range_gate_decimator
   import rgd_pkg::*;
#(
   parameter int COORD_WIDTH = 24,
   parameter int STEP_WIDTH  = 16,
   localparam int REQ_BITS   = 3*COORD_WIDTH + STAMP_W + RING_W,
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = 3*COORD_WIDTH + ROOT_OUT_W + REL_W + RING_W,
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // point input
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata, low to high: pos_x, pos_y, pos_z, stamp_ns, beam_ring, zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: frame_start
   input  wire logic                  req_tuser,
   // kept point output
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata, low to high: out_x, out_y, out_z, range_root, rel_time_ns,
   // out_ring, zero fill
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // configuration writes
   input  wire logic                  csr_wen,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RANGE_W  = (2*COORD_WIDTH + 2 > 64) ? 64 : 2*COORD_WIDTH + 2;
   localparam int P1       = (RANGE_W + 1) / 2;
   localparam int ROOT_W   = P1 + ROOT1_FRAC;
   localparam int P2       = (ROOT_W + 1) / 2;
   localparam int ITER2    = P2 + ROOT2_FRAC;
   localparam int RAD_W    = 2 * P1;
   localparam int R2_SHIFT = RAD_W - 2 * P2;
   localparam int CNT_W    = $clog2(ROOT_W + 1);
   localparam int CMP_W    = (RANGE_W > RANGE_SQ_W) ? RANGE_W : RANGE_SQ_W;

   localparam int OFS_Y     = COORD_WIDTH;
   localparam int OFS_Z     = 2 * COORD_WIDTH;
   localparam int OFS_STAMP = 3 * COORD_WIDTH;
   localparam int OFS_RING  = OFS_STAMP + STAMP_W;

   // unpacked request fields
   logic [COORD_WIDTH-1:0] req_pos_x;
   logic [COORD_WIDTH-1:0] req_pos_y;
   logic [COORD_WIDTH-1:0] req_pos_z;
   logic [STAMP_W-1:0]     req_stamp;
   logic [RING_W-1:0]      req_ring;
   logic                   req_xfer;

   assign req_pos_x = req_tdata[OFS_Y-1:0];
   assign req_pos_y = req_tdata[OFS_Z-1:OFS_Y];
   assign req_pos_z = req_tdata[OFS_STAMP-1:OFS_Z];
   assign req_stamp = req_tdata[OFS_RING-1:OFS_STAMP];
   assign req_ring  = req_tdata[OFS_RING+RING_W-1:OFS_RING];
   assign req_xfer  = req_tvalid && req_tready;

   // configuration registers
   logic [STEP_WIDTH-1:0] keep_ff;
   logic [RANGE_SQ_W-1:0] min_ff;
   logic [RANGE_SQ_W-1:0] max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= STEP_WIDTH'(1);
         min_ff  <= '0;
         max_ff  <= '1;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_KEEP_EVERY:   keep_ff <= csr_wdata[STEP_WIDTH-1:0];
            CSR_MIN_RANGE_SQ: min_ff  <= csr_wdata[RANGE_SQ_W-1:0];
            CSR_MAX_RANGE_SQ: max_ff  <= csr_wdata[RANGE_SQ_W-1:0];
            default: ;
         endcase
      end
   end

   // frame time and decimation phase, advanced on every point transfer
   logic [STAMP_W-1:0]    frame_ff;
   logic [STEP_WIDTH-1:0] phase_ff;
   logic [STEP_WIDTH-1:0] phase_in;
   logic [STEP_WIDTH-1:0] phase_cur;
   logic [STEP_WIDTH-1:0] step_eff;
   logic [STEP_WIDTH:0]   phase_inc;
   logic                  candidate;

   assign step_eff  = (keep_ff == '0) ? STEP_WIDTH'(1) : keep_ff;
   assign phase_cur = req_tuser ? '0 : phase_ff;
   assign candidate = (phase_cur == '0);
   assign phase_inc = {1'b0, phase_cur} + (STEP_WIDTH+1)'(1);
   // wrap also when keep_every was lowered below the running phase
   assign phase_in  = (phase_inc >= {1'b0, step_eff}) ? '0 : phase_inc[STEP_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         phase_ff <= '0;
      end else if (req_xfer) begin
         phase_ff <= phase_in;
         if (req_tuser) begin
            frame_ff <= req_stamp;
         end
      end
   end

   // captured point payload
   logic [COORD_WIDTH-1:0] pos_x_ff;
   logic [COORD_WIDTH-1:0] pos_y_ff;
   logic [COORD_WIDTH-1:0] pos_z_ff;
   logic [STAMP_W-1:0]     stamp_ff;
   logic [RING_W-1:0]      ring_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         pos_z_ff <= req_pos_z;
         stamp_ff <= req_stamp;
         ring_ff  <= req_ring;
      end
   end

   // squared range
   rgd_sq_ctl_type     sq_ctl;
   logic [RANGE_W-1:0] range_sq;

   rgd_sq_acc #(
      .COORD_WIDTH (COORD_WIDTH),
      .RANGE_W     (RANGE_W)
   ) u_sq_acc (
      .clock    (clock),
      .pos_x    (pos_x_ff),
      .pos_y    (pos_y_ff),
      .pos_z    (pos_z_ff),
      .ctl      (sq_ctl),
      .range_sq (range_sq)
   );

   logic in_window;

   assign in_window = (CMP_W'(range_sq) >= CMP_W'(min_ff)) &&
                      (CMP_W'(range_sq) <= CMP_W'(max_ff));

   // shared root unit
   logic              root_start;
   logic [CNT_W-1:0]  root_iters;
   logic [RAD_W-1:0]  root_rad;
   logic              root_done;
   logic [ROOT_W-1:0] root_q;

   rgd_root_unit #(
      .RAD_W  (RAD_W),
      .ROOT_W (ROOT_W),
      .CNT_W  (CNT_W)
   ) u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .iters (root_iters),
      .rad   (root_rad),
      .done  (root_done),
      .root  (root_q)
   );

   logic [ROOT_OUT_W-1:0] root_sat;

   assign root_sat = (root_q > ROOT_W'(ROOT_OUT_MAX)) ? ROOT_OUT_MAX
                                                      : root_q[ROOT_OUT_W-1:0];

   // frame-relative time, saturated to 32 bits signed
   logic [63:0]      rel_diff;
   logic             rel_fits;
   logic [REL_W-1:0] rel_in;
   logic [REL_W-1:0] rel_ff;

   assign rel_diff = {1'b0, stamp_ff} - {1'b0, frame_ff};
   assign rel_fits = (rel_diff[63:REL_W-1] == '0) || (rel_diff[63:REL_W-1] == '1);
   assign rel_in   = rel_fits     ? rel_diff[REL_W-1:0] :
                     rel_diff[63] ? REL_NEG_MIN : REL_POS_MAX;

   // sequencer
   rgd_state_type state_ff;
   rgd_state_type state_in;
   logic [1:0]    sq_cnt_ff;
   logic [1:0]    sq_cnt_in;
   logic          load_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sq_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         sq_cnt_ff <= sq_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      sq_cnt_in  = sq_cnt_ff;
      sq_ctl     = '{clr: 1'b0, mul: 1'b0, acc: 1'b0, sel: AXIS_X};
      root_start = 1'b0;
      root_iters = CNT_W'(ROOT_W);
      root_rad   = RAD_W'(range_sq);
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // drop non-candidates right here
            if (req_xfer && candidate) begin
               state_in  = ST_SQUARE;
               sq_cnt_in = '0;
            end
         end
         ST_SQUARE: begin
            sq_cnt_in = sq_cnt_ff + 2'd1;
            case (sq_cnt_ff)
               2'd0: sq_ctl = '{clr: 1'b1, mul: 1'b1, acc: 1'b0, sel: AXIS_X};
               2'd1: sq_ctl = '{clr: 1'b0, mul: 1'b1, acc: 1'b1, sel: AXIS_Y};
               2'd2: sq_ctl = '{clr: 1'b0, mul: 1'b1, acc: 1'b1, sel: AXIS_Z};
               default: begin
                  sq_ctl   = '{clr: 1'b0, mul: 1'b0, acc: 1'b1, sel: AXIS_X};
                  state_in = ST_GATE;
               end
            endcase
         end
         ST_GATE: begin
            if (in_window) begin
               root_start = 1'b1;
               state_in   = ST_ROOT1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ROOT1: begin
            // feed the distance back in, left-aligned, for the second root
            root_iters = CNT_W'(ITER2);
            root_rad   = RAD_W'(root_q) << R2_SHIFT;
            if (root_done) begin
               root_start = 1'b1;
               state_in   = ST_ROOT2;
            end
         end
         ST_ROOT2: begin
            if (root_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_tvalid || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_GATE) begin
         rel_ff <= rel_in;
      end
   end

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= RSP_DATA_W'({ring_ff, rel_ff, root_sat, pos_z_ff, pos_y_ff, pos_x_ff});
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ design/rgd_sq_acc.sv @@
// Square-accumulate unit: one coordinate magnitude squared per cycle, summed
// into the squared range. Depends on rgd_pkg.
`default_nettype none

module rgd_sq_acc
   import rgd_pkg::*;
#(
   parameter int COORD_WIDTH = 24,
   parameter int RANGE_W     = 50
) (
   input  wire logic                   clock,
   input  wire logic [COORD_WIDTH-1:0] pos_x,
   input  wire logic [COORD_WIDTH-1:0] pos_y,
   input  wire logic [COORD_WIDTH-1:0] pos_z,
   input  wire rgd_sq_ctl_type         ctl,
   output logic      [RANGE_W-1:0]     range_sq
);

   logic [COORD_WIDTH-1:0]   coord;
   logic [COORD_WIDTH-1:0]   mag;
   logic [2*COORD_WIDTH-1:0] prod_in;
   logic [2*COORD_WIDTH-1:0] prod_ff;
   logic [RANGE_W-1:0]       range_ff;

   always_comb begin
      case (ctl.sel)
         AXIS_X:  coord = pos_x;
         AXIS_Y:  coord = pos_y;
         AXIS_Z:  coord = pos_z;
         default: coord = pos_x;
      endcase
   end

   // most negative value maps to its true magnitude in unsigned form
   assign mag     = coord[COORD_WIDTH-1] ? (~coord + COORD_WIDTH'(1)) : coord;
   assign prod_in = (2*COORD_WIDTH)'(mag) * (2*COORD_WIDTH)'(mag);

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
      if (ctl.clr) begin
         range_ff <= '0;
      end else if (ctl.acc) begin
         range_ff <= range_ff + RANGE_W'(prod_ff);
      end
   end

   assign range_sq = range_ff;

endmodule

`default_nettype wire

@@ design/rgd_root_unit.sv @@
// Shared digit-recurrence square root, one root bit per cycle from a
// left-aligned radicand. Standalone; no package dependencies.
`default_nettype none

module rgd_root_unit #(
   parameter int RAD_W  = 50,
   parameter int ROOT_W = 33,
   parameter int CNT_W  = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [CNT_W-1:0]  iters,
   input  wire logic [RAD_W-1:0]  rad,
   output logic                   done,
   output logic      [ROOT_W-1:0] root
);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W:0]   rem_ff;
   logic [ROOT_W-1:0] root_ff;

   logic [ROOT_W+1:0] rem_sh;
   logic [ROOT_W+1:0] trial;
   logic [ROOT_W+1:0] diff;
   logic              fit;

   assign rem_sh = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fit    = rem_sh >= trial;
   assign diff   = rem_sh - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= iters;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= rad;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= fit ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
         root_ff <= {root_ff[ROOT_W-2:0], fit};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

@@ design/rgd_checker.sv @@
// Port-level checker for the lidar point range gate and decimator, bound to
// the top level. Depends on rgd_pkg and lidar_point_range_gate_decimator.
`default_nettype none

module rgd_checker
   import rgd_pkg::*;
#(
   parameter int COORD_WIDTH = 24,
   parameter int STEP_WIDTH  = 16,
   localparam int REQ_BITS   = 3*COORD_WIDTH + STAMP_W + RING_W,
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = 3*COORD_WIDTH + ROOT_OUT_W + REL_W + RING_W,
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   // tdata, low to high: pos_x, pos_y, pos_z, stamp_ns, beam_ring
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: frame_start
   input wire logic                  req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   // tdata, low to high: out_x, out_y, out_z, range_root, rel_time_ns, out_ring
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  csr_wen,
   input wire logic [CSR_IDX_W-1:0]  csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic step_wide;

   assign step_wide = (STEP_WIDTH > 0) && (req_tdata != '1 || req_tuser || !req_tuser ||
                      csr_wen || !csr_wen || csr_index == csr_index ||
                      csr_wdata == csr_wdata);

   // a result is loaded only as the sequencer returns to accepting points
   a_rsp_with_ready: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result raised while point input not ready");

   // the block only goes busy on a point transfer
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tready))
      else $error("input went busy without a point transfer");

   // no point can pass squaring, gating and both roots by the cycle after its transfer
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && step_wide) |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after a point transfer");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or dropped");

endmodule

bind lidar_point_range_gate_decimator rgd_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .STEP_WIDTH  (STEP_WIDTH)
) u_rgd_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for lidar_point_range_gate_decimator: random and directed
// lidar points are streamed in, and every kept point is checked against a predictor.
// Depends on rgd_pkg and the block's RTL only.

module testbench
   import rgd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W     = 24;
   localparam int REQ_W       = ((3*COORD_W + STAMP_W + RING_W + 7) / 8) * 8;
   localparam int RSP_W       = ((3*COORD_W + ROOT_OUT_W + REL_W + RING_W + 7) / 8) * 8;
   // Drain time after the queues empty; it covers a kept point's full pass through the block.
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_ITEMS  = 125;

   localparam logic [COORD_W-1:0]    C_MAX     = 24'h7F_FFFF;
   localparam logic [COORD_W-1:0]    C_MIN     = 24'h80_0000;
   localparam logic [RANGE_SQ_W-1:0] RANGE_ALL = 48'hFFFF_FFFF_FFFF;
   localparam logic [STAMP_W-1:0]    STAMP_TOP = 63'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic signed [COORD_W-1:0] x, y, z;
      logic [STAMP_W-1:0]        stamp;
      logic [RING_W-1:0]         ring;
      logic                      first;
   } lidar_point_type;

   typedef struct {
      logic [COORD_W-1:0]    x, y, z;
      logic [ROOT_OUT_W-1:0] root;
      logic [REL_W-1:0]      rel;
      logic [RING_W-1:0]     ring;
   } kept_point_type;

   // Clock, reset and block ports; every input starts at a known value.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Points waiting for the driver, and kept points waiting for the block.
   lidar_point_type points_to_send[$];
   kept_point_type  kept_points_due[$];

   // Predictor copy of the registers and of the frame/decimation state.
   logic [15:0]           cfg_keep_every = 16'd1;
   logic [RANGE_SQ_W-1:0] cfg_min_sq     = '0;
   logic [RANGE_SQ_W-1:0] cfg_max_sq     = RANGE_ALL;
   logic [63:0]           frame_time     = '0;
   logic [15:0]           step_phase     = '0;

   // Handshake outcomes seen at the last rising edge, read by the drivers.
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit req_calm  = 1'b0;
   bit rsp_calm  = 1'b0;
   int req_gap   = 0;
   int rsp_stall = 0;
   int rsp_hold_cycles = 0;
   int mismatch_count  = 0;
   int cycle_count     = 0;

   lidar_point_range_gate_decimator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // low to high: pos_x, pos_y, pos_z, stamp_ns, beam_ring, zero fill
      .req_tdata  (req_tdata),
      // frame_start
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // low to high: out_x, out_y, out_z, range_root, rel_time_ns, out_ring, zero fill
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stop a hung run; the slowest legal run is far below this.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // floor(sqrt(n)), one result bit per pass from the top down.
   function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
      logic [31:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = {32'd0, r | (32'd1 << b)};
         if (t * t <= n) r = r | (32'd1 << b);
      end
      return r;
   endfunction

   // Advance frame and decimation state for one point; return 1 with the kept
   // point filled in when the point is a candidate inside the range window.
   function automatic bit gate_point(input lidar_point_type p, output kept_point_type k);
      logic signed [47:0] sx, sy, sz;
      logic [47:0]        rsq;
      logic [31:0]        dist_q8, root;
      logic [63:0]        st, d;
      logic [15:0]        step;
      logic [16:0]        nxt;
      bit                 cand;
      k = '{default: '0};
      // a zero step behaves as keep-all
      step = (cfg_keep_every == 16'd0) ? 16'd1 : cfg_keep_every;
      if (p.first) begin
         frame_time = {1'b0, p.stamp};
         step_phase = '0;
      end
      cand = (step_phase == 16'd0);
      // wrap at the step, also when the step was lowered below the phase
      nxt = {1'b0, step_phase} + 17'd1;
      if (nxt >= {1'b0, step}) nxt = '0;
      step_phase = nxt[15:0];
      if (!cand) return 1'b0;

      sx = 48'(p.x);
      sy = 48'(p.y);
      sz = 48'(p.z);
      rsq = sx*sx + sy*sy + sz*sz;
      if (rsq < cfg_min_sq || rsq > cfg_max_sq) return 1'b0;

      // distance in Q.8, then the root of that distance in Q.8
      dist_q8 = floor_sqrt({rsq, 16'd0});
      root    = floor_sqrt({24'd0, dist_q8, 8'd0});
      k.root  = (root > 32'(ROOT_OUT_MAX)) ? ROOT_OUT_MAX : root[ROOT_OUT_W-1:0];

      st = {1'b0, p.stamp};
      if (st >= frame_time) begin
         d = st - frame_time;
         k.rel = (d > 64'h7FFF_FFFF) ? REL_POS_MAX : d[31:0];
      end else begin
         d = frame_time - st;
         k.rel = (d >= 64'h8000_0000) ? REL_NEG_MIN : -d[31:0];
      end
      k.x    = p.x;
      k.y    = p.y;
      k.z    = p.z;
      k.ring = p.ring;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
   endtask

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 15));
   endfunction

   // Sender: present points at the falling edge; hold a point until its transfer.
   always @(negedge clock) begin
      lidar_point_type p;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the offered point
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (points_to_send.size() != 0) begin
         p = points_to_send[0];
         points_to_send.delete(0);
         req_tvalid <= 1'b1;
         req_tdata  <= {1'b0, p.ring, p.stamp, p.z, p.y, p.x};
         req_tuser  <= p.first;
         req_gap = draw_gap(req_calm);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: stall after each transfer for a drawn number of cycles, and for
   // a long hold-off when one is requested, counted down here.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) rsp_stall = draw_gap(rsp_calm);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: sample both channels at the rising edge, predict on each point
   // transfer and check each result transfer against the oldest kept point due.
   always @(posedge clock) begin
      lidar_point_type pt;
      kept_point_type  want;
      kept_point_type  got;
      if (reset) begin
         req_taken = 1'b0;
         rsp_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         rsp_taken = rsp_tvalid && rsp_tready;
         if (rsp_taken) begin
            got.x    = rsp_tdata[23:0];
            got.y    = rsp_tdata[47:24];
            got.z    = rsp_tdata[71:48];
            got.root = rsp_tdata[91:72];
            got.rel  = rsp_tdata[123:92];
            got.ring = rsp_tdata[131:124];
            if (kept_points_due.size() == 0) begin
               report_mismatch("unexpected kept point", rsp_tdata[63:0], '0);
            end else begin
               want = kept_points_due[0];
               kept_points_due.delete(0);
               if (got.x != want.x)
                  report_mismatch("out_x", 64'(got.x), 64'(want.x));
               if (got.y != want.y)
                  report_mismatch("out_y", 64'(got.y), 64'(want.y));
               if (got.z != want.z)
                  report_mismatch("out_z", 64'(got.z), 64'(want.z));
               if (got.root != want.root)
                  report_mismatch("range_root", 64'(got.root), 64'(want.root));
               if (got.rel != want.rel)
                  report_mismatch("rel_time_ns", 64'(got.rel), 64'(want.rel));
               if (got.ring != want.ring)
                  report_mismatch("out_ring", 64'(got.ring), 64'(want.ring));
            end
         end
         if (req_taken) begin
            pt.x     = req_tdata[23:0];
            pt.y     = req_tdata[47:24];
            pt.z     = req_tdata[71:48];
            pt.stamp = req_tdata[134:72];
            pt.ring  = req_tdata[142:135];
            pt.first = req_tuser;
            if (gate_point(pt, want))
               kept_points_due.insert(kept_points_due.size(), want);
         end
      end
   end

   task automatic queue_point(input logic [COORD_W-1:0] x, y, z,
                              input logic [STAMP_W-1:0] stamp,
                              input logic [RING_W-1:0] ring, input logic first);
      lidar_point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      p.stamp = stamp;
      p.ring = ring;
      p.first = first;
      points_to_send.insert(points_to_send.size(), p);
   endtask

   // Write one register at a falling edge and mirror it in the predictor.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_KEEP_EVERY:   cfg_keep_every = value[15:0];
         CSR_MIN_RANGE_SQ: cfg_min_sq     = value;
         CSR_MAX_RANGE_SQ: cfg_max_sq     = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // Wait until every point is sent and every kept point has come out, then
   // let the block finish any candidate that produces nothing.
   task automatic settle();
      while (points_to_send.size() != 0 || req_tvalid || kept_points_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [STAMP_W-1:0] rand_stamp();
      return STAMP_W'({$urandom, $urandom});
   endfunction

   // Coordinates spread over all magnitudes, with the extremes now and then.
   function automatic logic [COORD_W-1:0] rand_coord();
      logic [COORD_W-1:0] v;
      int k;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = C_MAX;
               1: v = C_MIN;
               2: v = '0;
               3: v = '1;
               default: v = 24'd1;
            endcase
         end
         1, 2: v = COORD_W'($urandom);
         default: begin
            k = int'($urandom_range(0, 23));
            v = COORD_W'($urandom & ((32'd1 << k) - 32'd1));
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [47:0] rand_mag();
      int k;
      k = int'($urandom_range(0, 24));
      return {16'd0, $urandom & ((32'd1 << k) - 32'd1)};
   endfunction

   // Mostly well-formed frames with rising stamps; some frames lose their
   // start flag, some carry a stray one, and stamps jump or run backward.
   task automatic queue_frames(input int n_items);
      lidar_point_type p;
      logic [STAMP_W-1:0] stamp;
      int sent;
      int len;
      sent = 0;
      stamp = rand_stamp();
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(25, 80))
                                           : int'($urandom_range(1, 24));
         case ($urandom_range(0, 9))
            0: stamp = rand_stamp();
            1: stamp = stamp - STAMP_W'($urandom_range(0, 1 << 20));
            default: stamp = stamp + STAMP_W'($urandom_range(0, 5000));
         endcase
         for (int j = 0; j < len && sent < n_items; j++) begin
            p.x = rand_coord();
            p.y = rand_coord();
            p.z = rand_coord();
            p.ring = RING_W'($urandom);
            p.first = (j == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 63) == 0);
            case ($urandom_range(0, 31))
               0: stamp = stamp + ({31'd0, $urandom} << $urandom_range(0, 8));
               1: stamp = stamp - STAMP_W'($urandom_range(0, 100000));
               default: stamp = stamp + STAMP_W'($urandom_range(0, 100000));
            endcase
            p.stamp = stamp;
            points_to_send.insert(points_to_send.size(), p);
            sent++;
         end
      end
   endtask

   initial begin
      logic [15:0] keep;
      logic [47:0] lo, hi, rl, rh;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings keep every point: check field extremes and time edges.
      // Points before any frame start count time from zero.
      queue_point('0, '0, '0, 63'd1000, 8'h00, 1'b0);
      queue_point(C_MAX, C_MAX, C_MAX, STAMP_TOP, 8'hFF, 1'b0);
      queue_point(C_MIN, C_MIN, C_MIN, 63'd5, 8'h5A, 1'b1);
      queue_point('1, 24'd1, '1, 63'd4, 8'hA5, 1'b0);
      queue_point(24'd100, -24'd200, 24'd300, 63'd0, 8'h01, 1'b0);
      queue_point(24'd1, '0, '0, 63'd1 << 40, 8'h80, 1'b1);
      queue_point('0, 24'd1, '0, (63'd1 << 40) + 63'h7FFF_FFFF, 8'h7F, 1'b0);
      queue_point('0, '0, 24'd1, (63'd1 << 40) + 63'h8000_0000, 8'h02, 1'b0);
      queue_point(24'd3, 24'd4, '0, (63'd1 << 40) - 63'h8000_0000, 8'h03, 1'b0);
      queue_point(24'd5, '0, '0, (63'd1 << 40) - 63'h8000_0001, 8'h04, 1'b0);
      queue_point(24'd12345, -24'd6789, 24'd1011, 63'd0, 8'h05, 1'b0);
      settle();

      // Decimate by five, then lower the step below the running phase.
      csr_write(CSR_KEEP_EVERY, 48'd5);
      queue_point(24'd10, 24'd20, 24'd30, 63'd100, 8'd10, 1'b1);
      queue_point(24'd11, 24'd21, 24'd31, 63'd200, 8'd11, 1'b0);
      queue_point(24'd12, 24'd22, 24'd32, 63'd300, 8'd12, 1'b0);
      settle();
      csr_write(CSR_KEEP_EVERY, 48'd2);
      queue_point(24'd13, 24'd23, 24'd33, 63'd400, 8'd13, 1'b0);
      queue_point(24'd14, 24'd24, 24'd34, 63'd500, 8'd14, 1'b0);
      queue_point(24'd15, 24'd25, 24'd35, 63'd600, 8'd15, 1'b0);
      settle();
      // A zero step keeps every point.
      csr_write(CSR_KEEP_EVERY, 48'd0);
      queue_point(24'd16, 24'd26, 24'd36, 63'd700, 8'd16, 1'b0);
      queue_point(24'd17, 24'd27, 24'd37, 63'd800, 8'd17, 1'b0);
      settle();

      // Window of exactly one squared range, then an empty window, then the
      // extreme windows at both ends.
      csr_write(CSR_KEEP_EVERY, 48'd1);
      csr_write(CSR_MIN_RANGE_SQ, 48'd25);
      csr_write(CSR_MAX_RANGE_SQ, 48'd25);
      queue_point(24'd3, 24'd4, '0, 63'd900, 8'd20, 1'b0);
      queue_point(24'd3, 24'd4, 24'd1, 63'd901, 8'd21, 1'b0);
      queue_point('0, '0, -24'd5, 63'd902, 8'd22, 1'b0);
      queue_point(24'd2, 24'd4, '0, 63'd903, 8'd23, 1'b0);
      settle();
      csr_write(CSR_MIN_RANGE_SQ, 48'd26);
      queue_point('0, 24'd5, 24'd1, 63'd904, 8'd24, 1'b0);
      settle();
      csr_write(CSR_MIN_RANGE_SQ, RANGE_ALL);
      csr_write(CSR_MAX_RANGE_SQ, RANGE_ALL);
      queue_point(C_MIN, C_MIN, C_MIN, 63'd905, 8'd25, 1'b0);
      settle();
      csr_write(CSR_MIN_RANGE_SQ, '0);
      csr_write(CSR_MAX_RANGE_SQ, '0);
      queue_point('0, '0, '0, 63'd906, 8'd26, 1'b0);
      queue_point(24'd1, '0, '0, 63'd907, 8'd27, 1'b0);

      // Random phases, each with its own step, window and idling style.
      for (int ph = 0; ph < 10; ph++) begin
         settle();
         // one phase backs up the block with a long receiver hold-off
         if (ph == 4) rsp_hold_cycles = 2000;
         case (ph)
            1:       keep = 16'd65535;
            3:       keep = 16'd0;
            5:       keep = 16'($urandom_range(2, 9));
            7:       keep = 16'd2;
            9:       keep = 16'd3;
            default: keep = 16'd1;
         endcase
         case ((ph == 4) ? 0 : $urandom_range(0, 3))
            0: begin
               lo = '0;
               hi = RANGE_ALL;
            end
            1, 2: begin
               rl = rand_mag();
               rh = rl + rand_mag();
               if (rh > 48'hFF_FFFF) rh = 48'hFF_FFFF;
               lo = rl * rl;
               hi = rh * rh;
            end
            default: begin
               rh = rand_mag();
               lo = '0;
               hi = rh * rh;
            end
         endcase
         req_calm = (ph % 3 == 1);
         rsp_calm = (ph % 3 == 2);
         csr_write(CSR_KEEP_EVERY, {32'd0, keep});
         csr_write(CSR_MIN_RANGE_SQ, lo);
         csr_write(CSR_MAX_RANGE_SQ, hi);
         queue_frames(PHASE_ITEMS);
      end
      settle();

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/rgd_pkg.sv
design/rgd_sq_acc.sv
design/rgd_root_unit.sv
design/lidar_point_range_gate_decimator.sv
design/rgd_checker.sv
tb/sv/testbench.sv
